FILE: rtl/qph_pkg.sv
// shared widths, codes and slot word layout for the quadratic probe hash table
package qph_pkg;

  localparam int TABLE_SIZE_DEF = 16;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 10;
  localparam int MARK_W = 2;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_OCC   = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DEL   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] STAT_REMOVED  = 3'd5;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

endpackage

FILE: rtl/qph_mod.sv
// remainder unit: key mod table size by reciprocal multiplication, or the low key bits for a power-of-two size
module qph_mod
  import qph_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int AW         = $clog2(TABLE_SIZE)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [AW-1:0]    rem_o
);

  localparam bit             IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam int             SH      = KEY_W + AW;
  localparam int             PROD_W  = 2 * KEY_W + 1;
  localparam logic [KEY_W:0] RECIP   = (KEY_W+1)'((64'd1 << SH) / 64'(TABLE_SIZE));
  localparam logic [AW:0]    NW      = (AW+1)'(TABLE_SIZE);

  logic [AW-1:0]     rem_q;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] prod_q;
  logic              busy_q;
  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [AW:0]       q_lo;
  logic [AW:0]       qn_lo;
  logic [AW:0]       rem_est;
  logic [AW:0]       rem_fix;

  // quotient estimate is exact or one low, so the remainder is below twice the size
  assign prod    = PROD_W'(key_i) * PROD_W'(RECIP);
  assign q_lo    = prod_q[SH +: (AW+1)];
  assign qn_lo   = q_lo * NW;
  assign rem_est = key_q[AW:0] - qn_lo;
  assign rem_fix = (rem_est >= NW) ? (rem_est - NW) : rem_est;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      key_q  <= '0;
      prod_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        key_q  <= key_i;
        prod_q <= prod;
        if (IS_POW2) begin
          // power-of-two size: the remainder is the low key bits
          rem_q  <= key_i[AW-1:0];
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= rem_fix[AW-1:0];
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/qph_mem.sv
// slot memory: one write port, one synchronous read port
module qph_mem
  import qph_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int AW         = $clog2(TABLE_SIZE)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output slot_t         rdata_o
);

  slot_t mem [TABLE_SIZE];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/quadratic_probe_hash_table.sv
// quadratic probe hash table: request sequencer, probe walk and result register
// the walk probes one slot per cycle from the slot memory, starting at the home slot
// the home slot comes from a reciprocal-multiply remainder unit (the low key bits if 2^n)
// one request at a time: the next is taken once the result has moved to the output register
// reset: asynchronous, active low; a clearing pass then empties every slot,
//   with s_axis_tready low until it ends
module quadratic_probe_hash_table
  import qph_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // lookup_key [30:0], entry_value [62:31], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode [1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slot_index [9:0], found_value [41:10], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int            AW    = $clog2(TABLE_SIZE);
  localparam int            HW    = $clog2(6 * TABLE_SIZE + 1);
  localparam logic [AW:0]   N1    = (AW+1)'(TABLE_SIZE);
  localparam logic [AW+1:0] N2    = (AW+2)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST  = AW'(TABLE_SIZE - 1);
  localparam logic [HW-1:0] BOUND = HW'(6 * TABLE_SIZE);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_EVAL,
    ST_HOLD
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [AW-1:0]      home_q, home_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      s_q, s_d;
  logic [AW-1:0]      sq_q, sq_d;
  logic [HW-1:0]      h_q, h_d;
  logic [STAT_W-1:0]  res_stat_q, res_stat_d;
  logic [AW-1:0]      res_slot_q, res_slot_d;
  logic [VAL_W-1:0]   res_val_q, res_val_d;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [VAL_W-1:0]   out_val_q, out_val_d;

  logic               accept;
  logic               mod_start;
  logic               mod_done;
  logic [AW-1:0]      mod_rem;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  slot_t              mem_wdata;
  logic [AW-1:0]      mem_raddr;
  slot_t              rd;
  logic [AW:0]        idx_sum;
  logic [AW:0]        idx_red;
  logic [AW-1:0]      idx_nx;
  logic [AW+1:0]      sq_sum;
  logic [AW+1:0]      sq_red1;
  logic [AW+1:0]      sq_red2;
  logic               walk_end;
  logic               hit;
  logic               out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mod_start     = accept && (s_axis_tuser == MODE_INSERT ||
                                    s_axis_tuser == MODE_SEARCH ||
                                    s_axis_tuser == MODE_REMOVE);
  assign out_free      = !out_valid_q || m_axis_tready;

  qph_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (s_axis_tdata[KEY_W-1:0]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  qph_mem #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  // next probe slot and incremental square offset, all kept below the size
  assign idx_sum  = {1'b0, idx_q} + {1'b0, sq_q};
  assign idx_red  = (idx_sum >= N1) ? (idx_sum - N1) : idx_sum;
  assign idx_nx   = idx_red[AW-1:0];
  assign sq_sum   = (AW+2)'(sq_q) + (AW+2)'({s_q, 1'b1});
  assign sq_red1  = (sq_sum >= N2) ? (sq_sum - N2) : sq_sum;
  assign sq_red2  = (sq_red1 >= N2) ? (sq_red1 - N2) : sq_red1;
  assign walk_end = (idx_nx == home_q) || (h_q == BOUND);
  assign hit      = (rd.mark == MARK_OCC) && (rd.key == key_q);

  // while walking, the read for the following slot goes out with the evaluation
  assign mem_raddr = (state_q == ST_EVAL) ? idx_nx : idx_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    key_d       = key_q;
    val_d       = val_q;
    home_d      = home_q;
    idx_d       = idx_q;
    s_d         = s_q;
    sq_d        = sq_q;
    h_d         = h_q;
    res_stat_d  = res_stat_q;
    res_slot_d  = res_slot_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_slot_d  = out_slot_q;
    out_val_d   = out_val_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_d = s_axis_tuser;
          key_d  = s_axis_tdata[KEY_W-1:0];
          val_d  = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
          if (mod_start) begin
            state_d = ST_MOD;
          end else begin
            // unused mode: no walk, plain not-found
            res_stat_d = STAT_NOTFOUND;
            res_slot_d = '0;
            res_val_d  = '0;
            state_d    = ST_HOLD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          home_d  = mod_rem;
          idx_d   = mod_rem;
          s_d     = AW'(1);
          sq_d    = AW'(1);
          h_d     = HW'(1);
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        res_slot_d = '0;
        res_val_d  = '0;
        idx_d      = idx_nx;
        s_d        = (s_q == LAST) ? '0 : s_q + 1'b1;
        sq_d       = sq_red2[AW-1:0];
        h_d        = h_q + 1'b1;
        case (mode_q)
          MODE_INSERT: begin
            if (rd.mark != MARK_OCC || rd.key == key_q) begin
              mem_we     = 1'b1;
              mem_wdata  = '{mark: MARK_OCC, key: key_q, value: val_q};
              res_stat_d = (rd.mark != MARK_OCC) ? STAT_INSERTED : STAT_UPDATED;
              res_slot_d = idx_q;
              state_d    = ST_HOLD;
            end else if (walk_end) begin
              res_stat_d = STAT_FULL;
              state_d    = ST_HOLD;
            end
          end
          MODE_SEARCH, MODE_REMOVE: begin
            if (rd.mark == MARK_EMPTY) begin
              res_stat_d = STAT_NOTFOUND;
              state_d    = ST_HOLD;
            end else if (hit) begin
              res_slot_d = idx_q;
              state_d    = ST_HOLD;
              if (mode_q == MODE_SEARCH) begin
                res_stat_d = STAT_FOUND;
                res_val_d  = rd.value;
              end else begin
                mem_we     = 1'b1;
                mem_wdata  = '{mark: MARK_DEL, key: rd.key, value: rd.value};
                res_stat_d = STAT_REMOVED;
              end
            end else if (walk_end) begin
              res_stat_d = STAT_NOTFOUND;
              state_d    = ST_HOLD;
            end
          end
          default: begin
            res_stat_d = STAT_NOTFOUND;
            state_d    = ST_HOLD;
          end
        endcase
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_slot_d  = SLOT_W'(res_slot_q);
          out_val_d   = res_val_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mode_q      <= '0;
      key_q       <= '0;
      val_q       <= '0;
      home_q      <= '0;
      idx_q       <= '0;
      s_q         <= '0;
      sq_q        <= '0;
      h_q         <= '0;
      res_stat_q  <= '0;
      res_slot_q  <= '0;
      res_val_q   <= '0;
      out_valid_q <= 1'b0;
      out_stat_q  <= '0;
      out_slot_q  <= '0;
      out_val_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mode_q      <= mode_d;
      key_q       <= key_d;
      val_q       <= val_d;
      home_q      <= home_d;
      idx_q       <= idx_d;
      s_q         <= s_d;
      sq_q        <= sq_d;
      h_q         <= h_d;
      res_stat_q  <= res_stat_d;
      res_slot_q  <= res_slot_d;
      res_val_q   <= res_val_d;
      out_valid_q <= out_valid_d;
      out_stat_q  <= out_stat_d;
      out_slot_q  <= out_slot_d;
      out_val_q   <= out_val_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W-SLOT_W-VAL_W)'(0), out_val_q, out_slot_q};
  assign m_axis_tuser  = out_stat_q;

endmodule
